### sv/tmma_pkg.sv
`default_nettype none
package tmma_pkg;

  localparam int NUM_WORDS  = 1024;
  localparam int NUM_DOCS   = 1024;
  localparam int NUM_TOPICS = 16;

  localparam int ENTRY_W = 48;
  localparam int TT_W    = 58;
  localparam int DT_W    = 52;
  localparam int PROB_W  = 17;
  localparam int WEIGHT_W = 32;

  localparam int WT_DEPTH = NUM_TOPICS * NUM_WORDS;
  localparam int TD_DEPTH = NUM_DOCS * NUM_TOPICS;
  localparam int WT_AW    = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
  localparam int TD_AW    = (TD_DEPTH > 1) ? $clog2(TD_DEPTH) : 1;
  localparam int DT_AW    = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1;
  localparam int TT_AW    = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
  localparam int CLR_DEPTH = (WT_DEPTH > TD_DEPTH) ?
                             ((WT_DEPTH > NUM_DOCS) ? WT_DEPTH : NUM_DOCS) :
                             ((TD_DEPTH > NUM_DOCS) ? TD_DEPTH : NUM_DOCS);
  localparam int CLR_W    = $clog2(CLR_DEPTH + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACC   = 2'd1;
  localparam logic [1:0] CMD_RD_WZ = 2'd2;
  localparam logic [1:0] CMD_RD_ZD = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  word;
    logic [9:0]  doc;
    logic [3:0]  topic;
    logic [15:0] count;
    logic [15:0] posterior;
  } in_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              zero_total;
  } out_t;

endpackage
`default_nettype wire

### sv/tmma_div.sv
`default_nettype none
module tmma_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [tmma_pkg::ENTRY_W-1:0]       dividend,
  input  wire logic [tmma_pkg::TT_W-1:0]          divisor,
  output logic                                    done,
  output logic [tmma_pkg::PROB_W-1:0]             quotient
);

  localparam int REM_W = tmma_pkg::TT_W + 2;
  localparam int CNT_W = $clog2(tmma_pkg::PROB_W + 1);

  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [tmma_pkg::TT_W-1:0]   dvs_r;
  logic [tmma_pkg::PROB_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [REM_W-1:0]            diff;
  logic                        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    diff     = rem_r - REM_W'(dvs_r);
    ge       = rem_r >= REM_W'(dvs_r);
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = REM_W'(dividend);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(tmma_pkg::PROB_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? {diff[REM_W-2:0], 1'b0} : {rem_r[REM_W-2:0], 1'b0};
      q_nxt   = {q_r[tmma_pkg::PROB_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

### sv/topic_model_mstep_accumulator_top.sv
`default_nettype none
// topic model m-step accumulator
// in channel (in_valid/in_ready/in_data): one command per beat
//   clear zeroes every table, accumulate adds count*posterior into the
//   word-topic, topic-doc, topic-total and doc-total tables, the two read
//   commands return p(w|z) or p(z|d) in q1.16
// out channel (out_valid/out_ready/out_data): one beat per read command
// one command at a time; the steps of each:
//   accumulate: memory read, then saturating add and write back
//   read: memory read, then the one-bit-per-cycle divider unless the total
//   is zero; the result beat then goes out through the output register
//   clear: a sweep over the 16384 entries of the table memories, one entry a cycle
// reset: the same sweep runs first; in_ready stays low meanwhile
// when out_ready is low the finished result waits in the output register and
// the block keeps taking commands until a second result has to be presented
module topic_model_mstep_accumulator_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tmma_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tmma_pkg::out_t       out_data
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int EW = tmma_pkg::ENTRY_W;
  localparam int TW = tmma_pkg::TT_W;
  localparam int DW = tmma_pkg::DT_W;

  logic [2:0] state_r, state_nxt;
  logic [tmma_pkg::CLR_W-1:0] clr_r, clr_nxt;

  tmma_pkg::in_t item_r;
  logic [tmma_pkg::WEIGHT_W-1:0] weight_r;
  logic wz_ok_r, zd_ok_r, acc_ok_r;
  tmma_pkg::out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  tmma_pkg::out_t out_data_r;

  logic [EW-1:0] wt_mem [tmma_pkg::WT_DEPTH];
  logic [EW-1:0] td_mem [tmma_pkg::TD_DEPTH];
  logic [DW-1:0] dt_mem [tmma_pkg::NUM_DOCS];
  logic [TW-1:0] tt_r [tmma_pkg::NUM_TOPICS];
  logic [EW-1:0] wt_rd_r, td_rd_r;
  logic [DW-1:0] dt_rd_r;

  logic accept;
  logic w_ok, d_ok, z_ok;
  logic [tmma_pkg::WT_AW-1:0] wt_ra, wt_wa, wt_ia;
  logic [tmma_pkg::TD_AW-1:0] td_ra, td_wa, td_ia;
  logic [tmma_pkg::DT_AW-1:0] dt_wa;
  logic [tmma_pkg::TT_AW-1:0] tt_ia;
  logic wt_we, td_we, dt_we;
  logic [EW-1:0] wt_wd, td_wd;
  logic [DW-1:0] dt_wd;
  logic [EW:0] wt_sum, td_sum;
  logic [DW:0] dt_sum;
  logic [TW:0] tt_sum;
  logic [TW-1:0] tt_cur;
  logic [EW-1:0] rd_entry;
  logic [TW-1:0] rd_total;
  logic rd_ok;
  logic div_start, div_done;
  logic [tmma_pkg::PROB_W-1:0] div_q;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign w_ok = int'(in_data.word) < tmma_pkg::NUM_WORDS;
  assign d_ok = int'(in_data.doc) < tmma_pkg::NUM_DOCS;
  assign z_ok = int'(in_data.topic) < tmma_pkg::NUM_TOPICS;

  assign wt_ra = tmma_pkg::WT_AW'(int'(in_data.topic) * tmma_pkg::NUM_WORDS
                 + int'(in_data.word));
  assign td_ra = tmma_pkg::TD_AW'(int'(in_data.doc) * tmma_pkg::NUM_TOPICS
                 + int'(in_data.topic));
  assign wt_ia = tmma_pkg::WT_AW'(int'(item_r.topic) * tmma_pkg::NUM_WORDS
                 + int'(item_r.word));
  assign td_ia = tmma_pkg::TD_AW'(int'(item_r.doc) * tmma_pkg::NUM_TOPICS
                 + int'(item_r.topic));
  assign tt_ia = tmma_pkg::TT_AW'(item_r.topic);

  // saturating sums
  assign wt_sum = {1'b0, wt_rd_r} + (EW + 1)'(weight_r);
  assign td_sum = {1'b0, td_rd_r} + (EW + 1)'(weight_r);
  assign dt_sum = {1'b0, dt_rd_r} + (DW + 1)'(weight_r);
  assign tt_cur = tt_r[tt_ia];
  assign tt_sum = {1'b0, tt_cur} + (TW + 1)'(weight_r);

  always_comb begin
    wt_we = 1'b0;
    td_we = 1'b0;
    dt_we = 1'b0;
    wt_wa = wt_ia;
    td_wa = td_ia;
    dt_wa = tmma_pkg::DT_AW'(item_r.doc);
    wt_wd = wt_sum[EW] ? '1 : wt_sum[EW-1:0];
    td_wd = td_sum[EW] ? '1 : td_sum[EW-1:0];
    dt_wd = dt_sum[DW] ? '1 : dt_sum[DW-1:0];
    if (state_r == ST_CLR) begin
      wt_we = int'(clr_r) < tmma_pkg::WT_DEPTH;
      td_we = int'(clr_r) < tmma_pkg::TD_DEPTH;
      dt_we = int'(clr_r) < tmma_pkg::NUM_DOCS;
      wt_wa = tmma_pkg::WT_AW'(clr_r);
      td_wa = tmma_pkg::TD_AW'(clr_r);
      dt_wa = tmma_pkg::DT_AW'(clr_r);
      wt_wd = '0;
      td_wd = '0;
      dt_wd = '0;
    end else if (state_r == ST_ACC && acc_ok_r) begin
      wt_we = 1'b1;
      td_we = 1'b1;
      dt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_rd_r <= wt_mem[wt_ra];
  end

  always_ff @(posedge clk) begin
    if (td_we) td_mem[td_wa] <= td_wd;
    td_rd_r <= td_mem[td_ra];
  end

  always_ff @(posedge clk) begin
    if (dt_we) dt_mem[dt_wa] <= dt_wd;
    dt_rd_r <= dt_mem[tmma_pkg::DT_AW'(in_data.doc)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.command == tmma_pkg::CMD_CLEAR)) begin
      for (int i = 0; i < tmma_pkg::NUM_TOPICS; i++) tt_r[i] <= '0;
    end else if (state_r == ST_ACC && acc_ok_r) begin
      tt_r[tt_ia] <= tt_sum[TW] ? '1 : tt_sum[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_data;
      weight_r <= in_data.count * in_data.posterior;
      wz_ok_r  <= w_ok && z_ok;
      zd_ok_r  <= d_ok && z_ok;
      acc_ok_r <= w_ok && d_ok && z_ok;
    end
    res_r <= res_nxt;
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) out_data_r <= res_r;
  end

  // read operand selection
  always_comb begin
    if (item_r.command == tmma_pkg::CMD_RD_WZ) begin
      rd_entry = wt_rd_r;
      rd_total = tt_cur;
      rd_ok    = wz_ok_r;
    end else begin
      rd_entry = td_rd_r;
      rd_total = TW'(dt_rd_r);
      rd_ok    = zd_ok_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (int'(clr_r) == tmma_pkg::CLR_DEPTH - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            tmma_pkg::CMD_CLEAR: begin
              state_nxt = ST_CLR;
              clr_nxt   = '0;
            end
            tmma_pkg::CMD_ACC: state_nxt = ST_ACC;
            default: state_nxt = ST_RD;
          endcase
        end
      end
      ST_ACC: state_nxt = ST_IDLE;
      ST_RD: begin
        if (!rd_ok) begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (rd_total == '0) begin
          res_nxt.probability = '0;
          res_nxt.zero_total  = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.probability = div_q;
          res_nxt.zero_total  = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  tmma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_entry),
    .divisor  (rd_total),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
